@@ hdl/mmfb_pkg.sv @@
// mmfb_pkg: types, constants and the control-byte function of the
// master frame builder. Used by mmfb_emit and meter_master_frame_builder.
// No dependencies.
package mmfb_pkg;

   localparam int unsigned ADDR_W = 24;
   localparam int unsigned LEN_W  = 14;
   localparam int unsigned STEP_W = 5;

   localparam logic [7:0] START_CHAR = 8'h68;
   localparam logic [7:0] END_CHAR   = 8'h16;
   localparam logic [7:0] CTRL_BASE  = 8'h40;
   localparam logic [7:0] CTRL_CONF  = 8'h10;
   localparam logic [7:0] CTRL_FCB   = 8'h20;
   localparam logic [7:0] SEQ_MASK   = 8'h0f;
   localparam logic [15:0] HDR_EXTRA = 16'd8;

   // positions of the emitter inside one frame segment
   localparam logic [STEP_W-1:0] STEP_START1  = 5'd0;
   localparam logic [STEP_W-1:0] STEP_LEN1_LO = 5'd1;
   localparam logic [STEP_W-1:0] STEP_LEN1_HI = 5'd2;
   localparam logic [STEP_W-1:0] STEP_LEN2_LO = 5'd3;
   localparam logic [STEP_W-1:0] STEP_LEN2_HI = 5'd4;
   localparam logic [STEP_W-1:0] STEP_START2  = 5'd5;
   localparam logic [STEP_W-1:0] STEP_CTRL    = 5'd6;
   localparam logic [STEP_W-1:0] STEP_RGN0    = 5'd7;
   localparam logic [STEP_W-1:0] STEP_RGN1    = 5'd8;
   localparam logic [STEP_W-1:0] STEP_RGN2    = 5'd9;
   localparam logic [STEP_W-1:0] STEP_TRM0    = 5'd10;
   localparam logic [STEP_W-1:0] STEP_TRM1    = 5'd11;
   localparam logic [STEP_W-1:0] STEP_TRM2    = 5'd12;
   localparam logic [STEP_W-1:0] STEP_MST     = 5'd13;
   localparam logic [STEP_W-1:0] STEP_DATA    = 5'd14;
   localparam logic [STEP_W-1:0] STEP_SUM     = 5'd15;
   localparam logic [STEP_W-1:0] STEP_END     = 5'd16;

   // register indexes on the csr port
   localparam logic [1:0] REG_REGION   = 2'd0;
   localparam logic [1:0] REG_TERMINAL = 2'd1;
   localparam logic [1:0] REG_MASTER   = 2'd2;

   localparam logic OP_DATA   = 1'b0;
   localparam logic OP_TOGGLE = 1'b1;

   // one accepted word worth of output bytes
   typedef struct packed {
      logic        header;
      logic        tail;
      logic [7:0]  ctrl;
      logic [15:0] total;
      logic [7:0]  data;
      logic [7:0]  csum;
   } job_type;

   typedef struct packed {
      logic [ADDR_W-1:0] region;
      logic [ADDR_W-1:0] terminal;
      logic [7:0]        master;
   } addr_type;

   function automatic logic [7:0] control_byte(input logic [7:0] afn, input logic fcb);
      logic [7:0] code;
      logic       conf;
      code = 8'h00;
      conf = 1'b0;
      case (afn) inside
         8'd1: code = 8'd1;
         8'd2: code = 8'd9;
         8'd4: begin
            code = 8'd10;
            conf = 1'b1;
         end
         8'd6, 8'd10, [8'd12:8'd16], [8'd18:8'd21]: begin
            code = 8'd11;
            conf = 1'b1;
         end
         default: code = 8'h00;
      endcase
      if (conf) begin
         code = code + CTRL_CONF + (fcb ? CTRL_FCB : 8'h00);
      end
      return code + CTRL_BASE;
   endfunction

endpackage

@@ hdl/mmfb_emit.sv @@
// mmfb_emit: holds one prepared word and steps through its output bytes
// (header, data byte, checksum and end char). Depends on mmfb_pkg.
module mmfb_emit (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  mmfb_pkg::job_type job_in,
   input  mmfb_pkg::addr_type addr,
   output logic              free,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_frame_byte,
   output logic              rsp_last_of_frame
);
   import mmfb_pkg::*;

   job_type           job_ff, job_in_q;
   logic              valid_ff, valid_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [STEP_W-1:0] end_step;
   logic              done;

   assign end_step = job_ff.tail ? STEP_END : STEP_DATA;
   assign done     = valid_ff && rsp_ready && (step_ff == end_step);
   assign free     = !valid_ff || done;

   always_comb begin
      valid_in = valid_ff;
      step_in  = step_ff;
      job_in_q = job_ff;
      if (load) begin
         valid_in = 1'b1;
         job_in_q = job_in;
         step_in  = job_in.header ? STEP_START1 : STEP_DATA;
      end else if (done) begin
         valid_in = 1'b0;
      end else if (valid_ff && rsp_ready) begin
         step_in = step_ff + 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         step_ff  <= STEP_START1;
      end else begin
         valid_ff <= valid_in;
         step_ff  <= step_in;
      end
      job_ff <= job_in_q;
   end

   always_comb begin
      unique case (step_ff)
         STEP_START1:  rsp_frame_byte = START_CHAR;
         STEP_LEN1_LO: rsp_frame_byte = job_ff.total[7:0];
         STEP_LEN1_HI: rsp_frame_byte = job_ff.total[15:8];
         STEP_LEN2_LO: rsp_frame_byte = job_ff.total[7:0];
         STEP_LEN2_HI: rsp_frame_byte = job_ff.total[15:8];
         STEP_START2:  rsp_frame_byte = START_CHAR;
         STEP_CTRL:    rsp_frame_byte = job_ff.ctrl;
         STEP_RGN0:    rsp_frame_byte = addr.region[7:0];
         STEP_RGN1:    rsp_frame_byte = addr.region[15:8];
         STEP_RGN2:    rsp_frame_byte = addr.region[23:16];
         STEP_TRM0:    rsp_frame_byte = addr.terminal[7:0];
         STEP_TRM1:    rsp_frame_byte = addr.terminal[15:8];
         STEP_TRM2:    rsp_frame_byte = addr.terminal[23:16];
         STEP_MST:     rsp_frame_byte = addr.master;
         STEP_DATA:    rsp_frame_byte = job_ff.data;
         STEP_SUM:     rsp_frame_byte = job_ff.csum;
         STEP_END:     rsp_frame_byte = END_CHAR;
         default:      rsp_frame_byte = 8'h00;
      endcase
   end

   assign rsp_valid         = valid_ff;
   assign rsp_last_of_frame = (step_ff == STEP_END);

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> step_ff <= STEP_END)
      else $error("emitter step past end char");

   a_header_start: assert property (@(posedge clock) disable iff (reset)
      load && job_in.header |=> valid_ff && step_ff == STEP_START1)
      else $error("header word did not start at first start char");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      load |-> free)
      else $error("word loaded while previous one still pending");

endmodule

@@ hdl/meter_master_frame_builder.sv @@
// meter_master_frame_builder: top level of the master frame builder with
// csr registers, frame state and checksum. Depends on mmfb_pkg, mmfb_emit.
//
// Usage: user-data words come in on the req_ channel, one byte per word,
// the first of a frame being the function code with req_payload_length
// valid on it. req_operation high instead flips the frame-count bit and
// produces no output. Frame bytes leave on the rsp_ channel, with
// rsp_last_of_frame high on the closing end char.
// The first output byte of a word shows in the cycle after accept.
// Output bytes per word: a middle data word gives one byte; the first
// word of a frame gives 15 bytes (14 header bytes plus the data byte), the
// last word of a frame adds the checksum and end char. The single word holding
// register in mmfb_emit paces the words: a new word is taken in the cycle its
// last output byte is taken.
// A first byte with length 0 or above MAX_PAYLOAD is taken and dropped.
// Reset clears frame state, the frame-count bit, the sequence count and
// the address registers. When rsp_ready is low the current byte holds and
// req_ready stays low until the pending word's last byte goes out.
// Registers: region address at 0x0, terminal address at 0x4, master at 0x8.
module meter_master_frame_builder #(
   parameter int unsigned MAX_PAYLOAD = 16383
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_operation,
   input  logic [7:0]  req_payload_byte,
   input  logic [13:0] req_payload_length,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_frame_byte,
   output logic        rsp_last_of_frame,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import mmfb_pkg::*;

   localparam logic [16:0] MaxLen = 17'(MAX_PAYLOAD);

   logic [ADDR_W-1:0] region_ff, region_in;
   logic [ADDR_W-1:0] terminal_ff, terminal_in;
   logic [7:0]        master_ff, master_in;

   logic [LEN_W-1:0] pos_ff, pos_in;
   logic [LEN_W-1:0] flen_ff, flen_in;
   logic [7:0]       sum_ff, sum_in;
   logic [3:0]       seq_ff, seq_in;
   logic             fcb_ff, fcb_in;

   logic             wr_en;
   logic [1:0]       reg_idx;
   logic             accept;
   logic             first;
   logic             bad_len;
   logic             load;
   logic [LEN_W-1:0] flen_cur;
   logic [LEN_W-1:0] pos_next;
   logic             tail;
   logic [7:0]       data_b;
   logic [7:0]       ctrl;
   logic [7:0]       addr_sum;
   logic [7:0]       sum_base;
   logic [7:0]       sum_new;
   job_type          job;
   addr_type         addr;
   logic             emit_free;

   // csr port
   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[3:2];

   always_comb begin
      region_in   = region_ff;
      terminal_in = terminal_ff;
      master_in   = master_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_REGION:   region_in   = pwdata[ADDR_W-1:0];
            REG_TERMINAL: terminal_in = pwdata[ADDR_W-1:0];
            REG_MASTER:   master_in   = pwdata[7:0];
            default:      master_in   = master_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_REGION:   prdata = {8'h00, region_ff};
         REG_TERMINAL: prdata = {8'h00, terminal_ff};
         REG_MASTER:   prdata = {24'h000000, master_ff};
         default:      prdata = 32'h00000000;
      endcase
   end

   // word processing
   assign accept   = req_valid && req_ready;
   assign first    = (pos_ff == '0);
   assign bad_len  = (req_payload_length == '0) || (17'(req_payload_length) > MaxLen);
   assign flen_cur = first ? req_payload_length : flen_ff;
   assign pos_next = pos_ff + 14'd1;
   assign tail     = (pos_next >= flen_cur);
   // sequence bits go into the second data byte only
   assign data_b   = (pos_ff == 14'd1) ? (req_payload_byte | ({4'h0, seq_ff} & SEQ_MASK))
                                       : req_payload_byte;
   assign ctrl     = control_byte(req_payload_byte, fcb_ff);
   assign addr_sum = region_ff[7:0] + region_ff[15:8] + region_ff[23:16]
                   + terminal_ff[7:0] + terminal_ff[15:8] + terminal_ff[23:16]
                   + master_ff;
   assign sum_base = first ? (ctrl + addr_sum) : sum_ff;
   assign sum_new  = sum_base + data_b;

   assign load = accept && (req_operation == OP_DATA) && !(first && bad_len);

   always_comb begin
      job.header = first;
      job.tail   = tail;
      job.ctrl   = ctrl;
      job.total  = 16'(req_payload_length) + HDR_EXTRA;
      job.data   = data_b;
      job.csum   = sum_new;
   end

   always_comb begin
      pos_in  = pos_ff;
      flen_in = flen_ff;
      sum_in  = sum_ff;
      seq_in  = seq_ff;
      fcb_in  = fcb_ff;
      if (accept && req_operation == OP_TOGGLE) begin
         fcb_in = !fcb_ff;
      end else if (load) begin
         flen_in = flen_cur;
         if (tail) begin
            pos_in = '0;
            sum_in = 8'h00;
            seq_in = seq_ff + 4'd1;
         end else begin
            pos_in = pos_next;
            sum_in = sum_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         region_ff   <= '0;
         terminal_ff <= '0;
         master_ff   <= '0;
         pos_ff      <= '0;
         flen_ff     <= '0;
         sum_ff      <= '0;
         seq_ff      <= '0;
         fcb_ff      <= 1'b0;
      end else begin
         region_ff   <= region_in;
         terminal_ff <= terminal_in;
         master_ff   <= master_in;
         pos_ff      <= pos_in;
         flen_ff     <= flen_in;
         sum_ff      <= sum_in;
         seq_ff      <= seq_in;
         fcb_ff      <= fcb_in;
      end
   end

   assign addr.region   = region_ff;
   assign addr.terminal = terminal_ff;
   assign addr.master   = master_ff;

   assign req_ready = emit_free;

   mmfb_emit u_emit (
      .clock             (clock),
      .reset             (reset),
      .load              (load),
      .job_in            (job),
      .addr              (addr),
      .free              (emit_free),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_frame_byte    (rsp_frame_byte),
      .rsp_last_of_frame (rsp_last_of_frame)
   );

   a_pos_in_frame: assert property (@(posedge clock) disable iff (reset)
      pos_ff != '0 |-> pos_ff < flen_ff)
      else $error("byte position beyond latched frame length");

   a_seq_on_tail: assert property (@(posedge clock) disable iff (reset)
      load && tail |=> seq_ff == $past(seq_ff) + 4'd1 && pos_ff == '0)
      else $error("frame end did not advance sequence");

   a_toggle_silent: assert property (@(posedge clock) disable iff (reset)
      accept && req_operation == OP_TOGGLE |=> fcb_ff != $past(fcb_ff) && !$rose(rsp_valid))
      else $error("toggle word misbehaved");

endmodule

@@ verif/tb.sv @@
// tb: self-checking bench for meter_master_frame_builder, a frame scoreboard
// predicts every frame byte from accepted words and csr writes.
// Depends on mmfb_pkg and the meter_master_frame_builder rtl.
`timescale 1ns / 100ps

module tb;
   import mmfb_pkg::*;

   localparam int MAX_LEN = 16383;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       last_of_frame;
   } frame_out_type;

   class frame_scoreboard;
      logic [23:0] region;
      logic [23:0] terminal;
      logic [7:0]  master;
      logic [13:0] taken;
      logic [13:0] frame_len;
      logic [7:0]  sum;
      logic [3:0]  seq;
      logic        fcb;
      frame_out_type expected_bytes[$];
      int          errors;

      function new();
         region = '0;
         terminal = '0;
         master = '0;
         taken = '0;
         frame_len = '0;
         sum = '0;
         seq = '0;
         fcb = 1'b0;
         errors = 0;
      endfunction

      function void set_reg(input logic [1:0] idx, input logic [31:0] value);
         case (idx)
            REG_REGION: region = value[23:0];
            REG_TERMINAL: terminal = value[23:0];
            REG_MASTER: master = value[7:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_bytes.size();
      endfunction

      function logic [7:0] control_byte_for(input logic [7:0] afn);
         logic [7:0] code;
         case (afn)
            8'd1: return CTRL_BASE + 8'd1;
            8'd2: return CTRL_BASE + 8'd9;
            8'd4: code = 8'd10;
            8'd6, 8'd10, 8'd12, 8'd13, 8'd14, 8'd15, 8'd16, 8'd18, 8'd19, 8'd20,
            8'd21: code = 8'd11;
            default: return CTRL_BASE;
         endcase
         return CTRL_BASE + CTRL_CONF + code + (fcb ? CTRL_FCB : 8'h00);
      endfunction

      function void push_byte(input logic [7:0] b, input logic last);
         frame_out_type item;
         item.frame_byte = b;
         item.last_of_frame = last;
         expected_bytes.push_back(item);
      endfunction

      function void push_summed(input logic [7:0] b);
         push_byte(b, 1'b0);
         sum = sum + b;
      endfunction

      // one accepted word on the req channel
      function void note_word(input logic op, input logic [7:0] b, input logic [13:0] len);
         logic [15:0] total;
         logic [7:0]  data;
         data = b;
         if (op == OP_TOGGLE) begin
            fcb = ~fcb;
            return;
         end
         if (taken == 0) begin
            if (len == 0 || len > MAX_LEN) return;
            frame_len = len;
            total = {2'b00, len} + HDR_EXTRA;
            sum = '0;
            push_byte(START_CHAR, 1'b0);
            push_byte(total[7:0], 1'b0);
            push_byte(total[15:8], 1'b0);
            push_byte(total[7:0], 1'b0);
            push_byte(total[15:8], 1'b0);
            push_byte(START_CHAR, 1'b0);
            push_summed(control_byte_for(b));
            push_summed(region[7:0]);
            push_summed(region[15:8]);
            push_summed(region[23:16]);
            push_summed(terminal[7:0]);
            push_summed(terminal[15:8]);
            push_summed(terminal[23:16]);
            push_summed(master);
         end
         // sequence bits go into the second data byte only
         if (taken == 1) data = data | ({4'h0, seq} & SEQ_MASK);
         push_summed(data);
         taken = taken + 14'd1;
         if (taken >= frame_len) begin
            push_byte(sum, 1'b0);
            push_byte(END_CHAR, 1'b1);
            seq = seq + 4'd1;
            taken = '0;
            sum = '0;
         end
      endfunction

      task report(input string what, input logic [31:0] got, input logic [31:0] want);
         if (errors < 40) $display("mismatch, %s: got %0h, expected %0h", what, got, want);
         errors++;
      endtask

      task check_byte(input logic [7:0] fb, input logic last);
         frame_out_type want;
         if (expected_bytes.size() == 0) begin
            report("frame byte with none expected", {24'h0, fb}, 32'h0);
            return;
         end
         want = expected_bytes.pop_front();
         if (fb !== want.frame_byte) report("frame_byte", {24'h0, fb}, {24'h0, want.frame_byte});
         if (last !== want.last_of_frame) report("last_of_frame", {31'h0, last},
                                                 {31'h0, want.last_of_frame});
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_operation = OP_DATA;
   logic [7:0]  req_payload_byte = 8'h00;
   logic [13:0] req_payload_length = 14'h0000;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_frame_byte;
   logic        rsp_last_of_frame;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [3:0]  paddr = 4'h0;
   logic [31:0] pwdata = 32'h0;
   logic [31:0] prdata;
   logic        pready;

   frame_scoreboard sb = new();
   int gap_pct = 0;
   int stall_pct = 0;
   int word_count;
   logic [7:0] afn_list [14] = '{8'd1, 8'd2, 8'd4, 8'd6, 8'd10, 8'd12, 8'd13, 8'd14,
                                 8'd15, 8'd16, 8'd18, 8'd19, 8'd20, 8'd21};

   meter_master_frame_builder #(
      .MAX_PAYLOAD(MAX_LEN)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_operation(req_operation),
      .req_payload_byte(req_payload_byte),
      .req_payload_length(req_payload_length),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_frame_byte(rsp_frame_byte),
      .rsp_last_of_frame(rsp_last_of_frame),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always #10 clock = ~clock;

   // frame byte sink with random back-pressure
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_byte(rsp_frame_byte, rsp_last_of_frame);
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   task automatic send_word(input logic op, input logic [7:0] b, input logic [13:0] len);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_payload_byte <= b;
      req_payload_length <= len;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_word(op, b, len);
   endtask

   task automatic send_toggle();
      send_word(OP_TOGGLE, 8'($urandom_range(255)), 14'($urandom_range(MAX_LEN)));
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      sb.set_reg(idx, value);
   endtask

   task automatic program_addresses(input logic [23:0] rgn, input logic [23:0] trm,
                                    input logic [7:0] mst);
      write_reg(REG_REGION, {8'h00, rgn});
      write_reg(REG_TERMINAL, {8'h00, trm});
      write_reg(REG_MASTER, {24'h0, mst});
   endtask

   // wait for every expected byte, then let a trailing frame settle
   task automatic drain();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (sb.pending() != 0 && waited < 200000) begin
         @(posedge clock);
         waited++;
      end
      repeat (20) @(posedge clock);
   endtask

   // mostly complete frames with random content, some noise between them
   task automatic random_frame();
      logic [13:0] len;
      logic [7:0]  afn;
      int          pick;
      pick = $urandom_range(9);
      if (pick == 0) begin
         send_word(OP_DATA, 8'($urandom_range(255)), 14'd0);
         return;
      end
      if (pick == 1) begin
         send_toggle();
         word_count++;
         return;
      end
      len = ($urandom_range(7) == 0) ? 14'($urandom_range(24, 6)) : 14'($urandom_range(5, 1));
      afn = ($urandom_range(1) == 0) ? afn_list[$urandom_range(13)] : 8'($urandom_range(255));
      send_word(OP_DATA, afn, len);
      word_count++;
      for (int i = 1; i < len; i++) begin
         if ($urandom_range(9) == 0) begin
            send_toggle();
            word_count++;
         end
         send_word(OP_DATA, 8'($urandom_range(255)), 14'($urandom_range(MAX_LEN)));
         word_count++;
      end
   endtask

   task automatic random_part(input int target);
      word_count = 0;
      while (word_count < target) random_frame();
   endtask

   task automatic directed_part();
      // zero length on a first byte is dropped
      send_word(OP_DATA, 8'hFF, 14'd0);
      for (int k = 0; k < 14; k++) begin
         if (k == 7) send_toggle();
         send_word(OP_DATA, afn_list[k], 14'd1);
      end
      // sequence bits or'ed into a second byte, zero length mid-frame ignored
      send_word(OP_DATA, 8'h00, 14'd2);
      send_word(OP_DATA, 8'hF0, 14'd0);
      // toggle in the middle of a frame leaves the sent control byte alone
      send_word(OP_DATA, 8'hFF, 14'd3);
      send_toggle();
      send_word(OP_DATA, 8'h0F, 14'h3FFF);
      send_word(OP_DATA, 8'hFF, 14'h2AAA);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      gap_pct = 0;
      stall_pct = 0;
      program_addresses(24'hFFFFFF, 24'hFFFFFF, 8'hFF);
      directed_part();
      random_part(32);
      drain();

      gap_pct = 83;
      stall_pct = 0;
      program_addresses(24'h000000, 24'h000000, 8'h00);
      random_part(32);
      drain();

      gap_pct = 0;
      stall_pct = 83;
      program_addresses(24'($urandom), 24'($urandom), 8'($urandom_range(255)));
      random_part(32);
      drain();

      gap_pct = 7;
      stall_pct = 7;
      program_addresses(24'($urandom), 24'h800001, 8'($urandom_range(255)));
      random_part(32);
      drain();

      if (sb.pending() != 0) sb.report("frame bytes never sent", 32'(sb.pending()), 32'h0);
      if (sb.errors == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

   initial begin
      #(10_000_000);
      $display("tb failed");
      $finish;
   end

endmodule

@@ files.f @@
hdl/mmfb_pkg.sv
hdl/mmfb_emit.sv
hdl/meter_master_frame_builder.sv
verif/tb.sv
